// ----- sv/length_prefixed_frame_deframer_core_defines.svh -----
// Assertion macros for the length-prefixed frame deframer.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define LPFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while reset is released.
`define LPFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lpfd_pkg.sv -----
// Shared types and codes for the length-prefixed frame deframer.
// No dependencies; used by lpfd_scan and the top level.
`default_nettype none

package lpfd_pkg;

  localparam int unsigned KEY_LEN = 12;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_BODY    = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [2:0] NS_KEY    = 3'd0;
  localparam logic [2:0] NS_COLON  = 3'd1;
  localparam logic [2:0] NS_SPACE  = 3'd2;
  localparam logic [2:0] NS_SIGN   = 3'd3;
  localparam logic [2:0] NS_DIGITS = 3'd4;
  localparam logic [2:0] NS_DONE   = 3'd5;

  localparam logic [1:0] PART_HEADER  = 2'd0;
  localparam logic [1:0] PART_BODY    = 2'd1;
  localparam logic [1:0] PART_PAYLOAD = 2'd2;
  localparam logic [1:0] PART_IGNORED = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_ZERO_LEN     = 2'd1;
  localparam logic [1:0] ST_BODY_LONG    = 2'd2;
  localparam logic [1:0] ST_PAYLOAD_LONG = 2'd3;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic       CFG_MAX_BODY    = 1'b0;
  localparam logic       CFG_MAX_PAYLOAD = 1'b1;
  localparam logic [23:0] MAX_BODY_RESET    = 24'd65536;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd52428800;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [2:0]  stage;
    logic [3:0]  key_pos;
    logic [31:0] value;
    logic        sat;
    logic        negative;
  } scan_state_t;

  localparam scan_state_t SCAN_INIT = '{
    stage: NS_KEY, key_pos: 4'd0, value: 32'd0, sat: 1'b0, negative: 1'b0
  };

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h22;
      4'd1:    c = 8'h69;
      4'd2:    c = 8'h6D;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h67;
      4'd5:    c = 8'h65;
      4'd6:    c = 8'h5F;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h69;
      4'd9:    c = 8'h7A;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h22;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/length_prefixed_frame_deframer_core.sv -----
// Length-prefixed frame deframer, top level.
// Depends on lpfd_pkg, lpfd_scan and length_prefixed_frame_deframer_core_defines.svh.
//
// The input stream carries one byte per transaction in s_axis_tdata; s_axis_tuser set
// to one asks for a restart, which clears the frame state and any error hold.
// Each frame is a big-endian length of HEADER_BYTES bytes, a text body of that
// length and, when the body holds a nonzero value after the quoted size key, a binary
// payload.
// Every input transaction gives exactly one output transaction: the byte, its part
// and halt flag in m_axis_tuser, the status and extracted payload size in
// m_axis_tdata, and tlast on the byte that completes a frame.
// An accepted byte waits in the input register and is processed into the output register
// when that register is empty or its result is being taken. One byte per cycle is
// sustained while the receiver does not stall; the frame state update between the two
// registers sets that figure.
// When the receiver stalls, the output register holds its result and an empty input
// register still takes one more byte, after which s_axis_tready falls.
// Reset empties both registers, returns to the header phase and loads the limit
// registers with 65536 and 52428800. The configuration channel is always ready
// and must only be written while no transaction is in flight.
`default_nettype none
`include "length_prefixed_frame_deframer_core_defines.svh"

module length_prefixed_frame_deframer_core #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tuser,  // [0] action
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [7:0] byte_out, [9:8] status,
                                          // [41:10] payload_size, [47:42] zero
  output logic [2:0]       m_axis_tuser,  // [1:0] byte_part, [2] halted
  output logic             m_axis_tlast   // frame_end
);

  localparam int unsigned HIDX_W = (HEADER_BYTES < 2) ? 1 : $clog2(HEADER_BYTES + 1);
  localparam logic [HIDX_W-1:0] HDR_LAST = HIDX_W'(HEADER_BYTES);

  // Configuration registers.
  logic [23:0] max_body_q;
  logic [31:0] max_payload_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q    <= lpfd_pkg::MAX_BODY_RESET;
      max_payload_q <= lpfd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == lpfd_pkg::CFG_MAX_BODY) begin
        max_body_q <= cfg_data_i[23:0];
      end else begin
        max_payload_q <= cfg_data_i;
      end
    end
  end

  // Input register.
  logic       in_valid_q;
  logic       act_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      act_q  <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  // Frame state.
  logic [1:0]            phase_q, phase_d;
  logic [HIDX_W-1:0]     hidx_q, hidx_d, hidx_inc;
  logic [31:0]           body_q, body_d, body_shift;
  logic [31:0]           rem_q, rem_d, rem_dec;
  lpfd_pkg::scan_state_t scan_q, scan_d, scan_next;
  logic                  hold_q, hold_d;
  logic [31:0]           number;

  logic [7:0]  res_byte;
  logic [1:0]  res_part;
  logic        res_end;
  logic [1:0]  res_status;
  logic [31:0] res_size;

  lpfd_scan u_scan (
    .state_i  (scan_q),
    .byte_i   (byte_q),
    .state_o  (scan_next),
    .number_o (number)
  );

  assign hidx_inc   = hidx_q + HIDX_W'(1);
  assign body_shift = (body_q > 32'h00FF_FFFF) ? 32'hFFFF_FFFF : {body_q[23:0], byte_q};
  assign rem_dec    = (rem_q != 32'd0) ? (rem_q - 32'd1) : 32'd0;

  always_comb begin
    logic clear;
    clear      = 1'b0;
    phase_d    = phase_q;
    hidx_d     = hidx_q;
    body_d     = body_q;
    rem_d      = rem_q;
    scan_d     = scan_q;
    hold_d     = hold_q;
    res_byte   = byte_q;
    res_part   = lpfd_pkg::PART_IGNORED;
    res_end    = 1'b0;
    res_status = lpfd_pkg::ST_OK;
    res_size   = 32'd0;

    if (act_q == lpfd_pkg::ACT_RESTART) begin
      clear    = 1'b1;
      hold_d   = 1'b0;
      res_byte = 8'd0;
    end else if (!hold_q) begin
      case (phase_q)
        lpfd_pkg::PH_HEADER: begin
          res_part = lpfd_pkg::PART_HEADER;
          body_d   = body_shift;
          hidx_d   = hidx_inc;
          if (hidx_inc >= HDR_LAST) begin
            hidx_d = '0;
            if (body_shift == 32'd0) begin
              res_status = lpfd_pkg::ST_ZERO_LEN;
            end else if (body_shift > {8'd0, max_body_q}) begin
              res_status = lpfd_pkg::ST_BODY_LONG;
            end else begin
              rem_d   = body_shift;
              scan_d  = lpfd_pkg::SCAN_INIT;
              phase_d = lpfd_pkg::PH_BODY;
            end
          end
        end
        lpfd_pkg::PH_BODY: begin
          res_part = lpfd_pkg::PART_BODY;
          scan_d   = scan_next;
          rem_d    = rem_dec;
          if (rem_dec == 32'd0) begin
            res_size = number;
            if (number == 32'd0) begin
              res_end = 1'b1;
              clear   = 1'b1;
            end else if (number > max_payload_q) begin
              res_status = lpfd_pkg::ST_PAYLOAD_LONG;
            end else begin
              rem_d   = number;
              phase_d = lpfd_pkg::PH_PAYLOAD;
            end
          end
        end
        lpfd_pkg::PH_PAYLOAD: begin
          res_part = lpfd_pkg::PART_PAYLOAD;
          rem_d    = rem_dec;
          if (rem_dec == 32'd0) begin
            res_end = 1'b1;
            clear   = 1'b1;
          end
        end
        default: begin
          clear = 1'b1;
        end
      endcase
      if (res_status != lpfd_pkg::ST_OK) begin
        clear  = 1'b1;
        hold_d = 1'b1;
      end
    end

    if (clear) begin
      phase_d = lpfd_pkg::PH_HEADER;
      hidx_d  = '0;
      body_d  = 32'd0;
      rem_d   = 32'd0;
      scan_d  = lpfd_pkg::SCAN_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpfd_pkg::PH_HEADER;
      hidx_q  <= '0;
      body_q  <= 32'd0;
      rem_q   <= 32'd0;
      scan_q  <= lpfd_pkg::SCAN_INIT;
      hold_q  <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      body_q  <= body_d;
      rem_q   <= rem_d;
      scan_q  <= scan_d;
      hold_q  <= hold_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_axis_tdata <= {6'd0, res_size, res_status, res_byte};
      m_axis_tuser <= {hold_d, res_part};
      m_axis_tlast <= res_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  `LPFD_ASSERT_NOW(a_status_halts,
    m_axis_tvalid && (m_axis_tdata[9:8] != lpfd_pkg::ST_OK), m_axis_tuser[2],
    "error status without halt flag")
  `LPFD_ASSERT_NOW(a_hold_in_header, hold_q,
    (phase_q == lpfd_pkg::PH_HEADER) && (hidx_q == '0) && (body_q == 32'd0),
    "error hold with frame state not cleared")
  `LPFD_ASSERT_NEXT(a_restart_clears, advance && (act_q == lpfd_pkg::ACT_RESTART),
    !hold_q && (phase_q == lpfd_pkg::PH_HEADER), "restart did not clear the frame state")
  `LPFD_ASSERT_NOW(a_end_in_frame, m_axis_tvalid && m_axis_tlast,
    (m_axis_tuser[1:0] == lpfd_pkg::PART_BODY) || (m_axis_tuser[1:0] == lpfd_pkg::PART_PAYLOAD),
    "frame end on a byte outside body or payload")

endmodule

`default_nettype wire

// ----- sv/lpfd_scan.sv -----
// Key search and decimal number parser for one body byte.
// Purely combinational; depends on lpfd_pkg.
`default_nettype none

module lpfd_scan (
  input  var lpfd_pkg::scan_state_t state_i,
  input  wire logic [7:0]           byte_i,
  output lpfd_pkg::scan_state_t     state_o,
  output logic [31:0]               number_o
);

  logic        is_space;
  logic        is_digit;
  logic [35:0] times_ten;
  logic [35:0] next_acc;
  logic [3:0]  digit;

  assign is_space = (byte_i == 8'h20) || (byte_i inside {[8'h09:8'h0D]});
  assign is_digit = byte_i inside {[8'h30:8'h39]};
  assign digit    = 4'(byte_i - lpfd_pkg::CH_ZERO);

  assign times_ten = {1'b0, state_i.value, 3'b000} + {3'b000, state_i.value, 1'b0};
  assign next_acc  = times_ten + {32'd0, digit};

  always_comb begin
    state_o = state_i;
    case (state_i.stage)
      lpfd_pkg::NS_KEY: begin
        if ((state_i.key_pos < 4'(lpfd_pkg::KEY_LEN)) &&
            (byte_i == lpfd_pkg::key_char(state_i.key_pos))) begin
          state_o.key_pos = state_i.key_pos + 4'd1;
        end else begin
          state_o.key_pos = (byte_i == lpfd_pkg::CH_QUOTE) ? 4'd1 : 4'd0;
        end
        if (state_o.key_pos >= 4'(lpfd_pkg::KEY_LEN)) begin
          state_o.stage = lpfd_pkg::NS_COLON;
        end
      end
      lpfd_pkg::NS_COLON: begin
        if (byte_i == lpfd_pkg::CH_COLON) begin
          state_o.stage = lpfd_pkg::NS_SPACE;
        end
      end
      lpfd_pkg::NS_SPACE: begin
        if (is_space) begin
          state_o.stage = lpfd_pkg::NS_SPACE;
        end else if ((byte_i == lpfd_pkg::CH_PLUS) || (byte_i == lpfd_pkg::CH_MINUS)) begin
          state_o.negative = (byte_i == lpfd_pkg::CH_MINUS);
          state_o.stage    = lpfd_pkg::NS_SIGN;
        end else if (is_digit) begin
          state_o.value = next_acc[31:0];
          state_o.sat   = |next_acc[35:32];
          state_o.stage = lpfd_pkg::NS_DIGITS;
        end else begin
          state_o.value = 32'd0;
          state_o.stage = lpfd_pkg::NS_DONE;
        end
      end
      lpfd_pkg::NS_SIGN: begin
        if (is_digit) begin
          state_o.value = next_acc[31:0];
          state_o.sat   = |next_acc[35:32];
          state_o.stage = lpfd_pkg::NS_DIGITS;
        end else begin
          state_o.value    = 32'd0;
          state_o.negative = 1'b0;
          state_o.stage    = lpfd_pkg::NS_DONE;
        end
      end
      lpfd_pkg::NS_DIGITS: begin
        if (is_digit) begin
          if (!state_i.sat) begin
            state_o.value = next_acc[31:0];
            state_o.sat   = |next_acc[35:32];
          end
        end else begin
          state_o.stage = lpfd_pkg::NS_DONE;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  always_comb begin
    if ((state_o.stage != lpfd_pkg::NS_DIGITS) && (state_o.stage != lpfd_pkg::NS_DONE)) begin
      number_o = 32'd0;
    end else if (state_o.sat) begin
      number_o = 32'hFFFF_FFFF;
    end else if (state_o.negative) begin
      number_o = 32'd0 - state_o.value;
    end else begin
      number_o = state_o.value;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for length_prefixed_frame_deframer_core: drives framed byte
// streams with random stalls, predicts every output transaction and compares them in order.
// Depends on lpfd_pkg and the core's RTL only.
`timescale 1ns / 100ps

module tb;

  localparam int HDR_BYTES = 4;
  localparam logic [95:0] SIZE_KEY = 96'h2269_6D61_6765_5F73_697A_6522;
  localparam logic [32:0] NUM_SAT = 33'h1_0000_0000;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  part;
    logic        frame_end;
    logic [1:0]  status;
    logic [31:0] payload_size;
    logic        halted;
  } deframe_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Predicted block state and limit registers.
  logic [23:0] lim_body;
  logic [31:0] lim_payload;
  logic [1:0]  pred_phase;
  int          pred_hdr_idx;
  logic [31:0] pred_body_len;
  logic [31:0] pred_remain;
  logic [3:0]  pred_key_pos;
  logic [2:0]  pred_stage;
  logic [32:0] pred_value;
  logic        pred_negative;
  logic        pred_held;

  deframe_result_t pending_results[$];
  logic [7:0]      frame_body[$];
  int              mismatch_count;
  int              items_counted;
  int              idle_pct;
  int              stall_pct;
  int              hold_request;
  int              hold_left;

  length_prefixed_frame_deframer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic string size_key_text();
    string s;
    s = "";
    for (int i = 0; i < lpfd_pkg::KEY_LEN; i++) begin
      s = $sformatf("%s%c", s, SIZE_KEY[95 - 8 * i -: 8]);
    end
    return s;
  endfunction

  function automatic void clear_frame_state();
    pred_phase    = lpfd_pkg::PH_HEADER;
    pred_hdr_idx  = 0;
    pred_body_len = '0;
    pred_remain   = '0;
    pred_key_pos  = '0;
    pred_stage    = lpfd_pkg::NS_KEY;
    pred_value    = '0;
    pred_negative = 1'b0;
  endfunction

  function automatic void accumulate_digit(input logic [7:0] b);
    logic [36:0] acc;
    if (pred_value < NUM_SAT) begin
      acc = pred_value * 37'd10 + 37'(b - lpfd_pkg::CH_ZERO);
      pred_value = (acc > 37'hFFFF_FFFF) ? NUM_SAT : acc[32:0];
    end
  endfunction

  function automatic void scan_body_byte(input logic [7:0] b);
    logic is_digit;
    logic is_space;
    is_digit = (b >= lpfd_pkg::CH_ZERO) && (b <= 8'h39);
    is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    case (pred_stage)
      lpfd_pkg::NS_KEY: begin
        if (pred_key_pos < lpfd_pkg::KEY_LEN && b == SIZE_KEY[95 - 8 * pred_key_pos -: 8]) begin
          pred_key_pos = pred_key_pos + 4'd1;
        end else begin
          pred_key_pos = (b == lpfd_pkg::CH_QUOTE) ? 4'd1 : 4'd0;
        end
        if (pred_key_pos >= lpfd_pkg::KEY_LEN) pred_stage = lpfd_pkg::NS_COLON;
      end
      lpfd_pkg::NS_COLON: begin
        if (b == lpfd_pkg::CH_COLON) pred_stage = lpfd_pkg::NS_SPACE;
      end
      lpfd_pkg::NS_SPACE: begin
        if (is_space) begin
        end else if (b == lpfd_pkg::CH_PLUS || b == lpfd_pkg::CH_MINUS) begin
          pred_negative = (b == lpfd_pkg::CH_MINUS);
          pred_stage = lpfd_pkg::NS_SIGN;
        end else if (is_digit) begin
          accumulate_digit(b);
          pred_stage = lpfd_pkg::NS_DIGITS;
        end else begin
          pred_value = '0;
          pred_stage = lpfd_pkg::NS_DONE;
        end
      end
      lpfd_pkg::NS_SIGN: begin
        if (is_digit) begin
          accumulate_digit(b);
          pred_stage = lpfd_pkg::NS_DIGITS;
        end else begin
          pred_value = '0;
          pred_negative = 1'b0;
          pred_stage = lpfd_pkg::NS_DONE;
        end
      end
      lpfd_pkg::NS_DIGITS: begin
        if (is_digit) accumulate_digit(b);
        else pred_stage = lpfd_pkg::NS_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] extracted_size();
    if (pred_stage != lpfd_pkg::NS_DIGITS && pred_stage != lpfd_pkg::NS_DONE) return '0;
    if (pred_value >= NUM_SAT) return 32'hFFFF_FFFF;
    if (pred_negative) return 32'd0 - pred_value[31:0];
    return pred_value[31:0];
  endfunction

  function automatic deframe_result_t predict_deframe(input logic act, input logic [7:0] b);
    deframe_result_t r;
    r = '{byte_out: b, part: lpfd_pkg::PART_IGNORED, frame_end: 1'b0,
          status: lpfd_pkg::ST_OK, payload_size: '0, halted: 1'b0};
    if (act == lpfd_pkg::ACT_RESTART) begin
      clear_frame_state();
      pred_held = 1'b0;
      r.byte_out = '0;
    end else if (!pred_held) begin
      if (pred_phase == lpfd_pkg::PH_HEADER) begin
        r.part = lpfd_pkg::PART_HEADER;
        if (pred_body_len > 32'h00FF_FFFF) pred_body_len = 32'hFFFF_FFFF;
        else pred_body_len = {pred_body_len[23:0], b};
        pred_hdr_idx++;
        if (pred_hdr_idx >= HDR_BYTES) begin
          pred_hdr_idx = 0;
          if (pred_body_len == 0) begin
            r.status = lpfd_pkg::ST_ZERO_LEN;
          end else if (pred_body_len > {8'd0, lim_body}) begin
            r.status = lpfd_pkg::ST_BODY_LONG;
          end else begin
            pred_remain   = pred_body_len;
            pred_key_pos  = '0;
            pred_stage    = lpfd_pkg::NS_KEY;
            pred_value    = '0;
            pred_negative = 1'b0;
            pred_phase    = lpfd_pkg::PH_BODY;
          end
        end
      end else if (pred_phase == lpfd_pkg::PH_BODY) begin
        r.part = lpfd_pkg::PART_BODY;
        scan_body_byte(b);
        if (pred_remain != 0) pred_remain = pred_remain - 1;
        if (pred_remain == 0) begin
          r.payload_size = extracted_size();
          if (r.payload_size == 0) begin
            r.frame_end = 1'b1;
            clear_frame_state();
          end else if (r.payload_size > lim_payload) begin
            r.status = lpfd_pkg::ST_PAYLOAD_LONG;
          end else begin
            pred_remain = r.payload_size;
            pred_phase = lpfd_pkg::PH_PAYLOAD;
          end
        end
      end else if (pred_phase == lpfd_pkg::PH_PAYLOAD) begin
        r.part = lpfd_pkg::PART_PAYLOAD;
        if (pred_remain != 0) pred_remain = pred_remain - 1;
        if (pred_remain == 0) begin
          r.frame_end = 1'b1;
          clear_frame_state();
        end
      end else begin
        clear_frame_state();
      end
      if (r.status != lpfd_pkg::ST_OK) begin
        clear_frame_state();
        pred_held = 1'b1;
      end
    end
    r.halted = pred_held;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    if (mismatch_count < 10) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    deframe_result_t got;
    deframe_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{byte_out: m_axis_tdata[7:0], part: m_axis_tuser[1:0], frame_end: m_axis_tlast,
              status: m_axis_tdata[9:8], payload_size: m_axis_tdata[41:10],
              halted: m_axis_tuser[2]};
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected output transaction %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[47:42] !== '0) begin
          note_failure($sformatf("mismatch: expected %p, got %p, pad %0h", want, got,
                                 m_axis_tdata[47:42]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b);
    deframe_result_t exp_r;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_r = predict_deframe(act, b);
    pending_results.push_back(exp_r);
    if (act == lpfd_pkg::ACT_RESTART || exp_r.part != lpfd_pkg::PART_IGNORED) items_counted++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [31:0] body_data, input logic [31:0] payload_data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= lpfd_pkg::CFG_MAX_BODY;
    cfg_data_i  <= body_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    lim_body = body_data[23:0];
    cfg_index_i <= lpfd_pkg::CFG_MAX_PAYLOAD;
    cfg_data_i  <= payload_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    lim_payload = payload_data;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_header(input logic [31:0] len);
    for (int i = HDR_BYTES - 1; i >= 0; i--) send_item(lpfd_pkg::ACT_BYTE, len[8 * i +: 8]);
  endtask

  task automatic send_text_frame(input string body);
    send_header(body.len());
    for (int i = 0; i < body.len(); i++) send_item(lpfd_pkg::ACT_BYTE, body[i]);
  endtask

  task automatic finish_frame();
    int n;
    n = 0;
    while (pred_phase == lpfd_pkg::PH_PAYLOAD && n < 48) begin
      send_item(lpfd_pkg::ACT_BYTE, 8'($urandom_range(255)));
      n++;
    end
    if (pred_phase == lpfd_pkg::PH_PAYLOAD) begin
      send_item(lpfd_pkg::ACT_RESTART, 8'($urandom_range(255)));
    end
    if (pred_held) begin
      repeat ($urandom_range(3)) send_item(lpfd_pkg::ACT_BYTE, 8'($urandom_range(255)));
      send_item(lpfd_pkg::ACT_RESTART, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_header_errors();
    send_header(32'd0);
    send_item(lpfd_pkg::ACT_BYTE, 8'hFF);
    send_item(lpfd_pkg::ACT_BYTE, 8'h00);
    send_item(lpfd_pkg::ACT_RESTART, 8'hFF);
    send_header(32'hFFFF_FFFF);
    send_item(lpfd_pkg::ACT_RESTART, 8'h00);
    send_item(lpfd_pkg::ACT_BYTE, 8'h00);
    send_item(lpfd_pkg::ACT_BYTE, 8'h12);
    send_item(lpfd_pkg::ACT_RESTART, 8'h00);
  endtask

  task automatic test_size_key_frame();
    send_text_frame({"\"image", size_key_text(), " : \t+3,"});
    send_item(lpfd_pkg::ACT_BYTE, 8'h00);
    send_item(lpfd_pkg::ACT_BYTE, 8'hFF);
    send_item(lpfd_pkg::ACT_BYTE, 8'h5A);
    send_text_frame({size_key_text(), ":99999999999"});
    finish_frame();
  endtask

  task automatic test_limit_extremes();
    drain_results();
    write_limits(32'h0000_0000, 32'd0);
    send_header(32'd1);
    finish_frame();
    drain_results();
    write_limits(32'hA5FF_FFFF, 32'd0);
    send_header(32'h0100_0000);
    finish_frame();
    drain_results();
    write_limits(32'd16, 32'd0);
    send_text_frame({size_key_text(), ":1"});
    finish_frame();
    drain_results();
    write_limits(32'd1, 32'hFFFF_FFFF);
    send_text_frame("7");
    send_text_frame({size_key_text(), ":-4"});
    drain_results();
  endtask

  task automatic build_random_body();
    int kind;
    int sp;
    int digits;
    string num;
    frame_body = {};
    kind = $urandom_range(9);
    repeat ($urandom_range(4)) frame_body.push_back(8'($urandom_range(255)));
    if (kind < 2) begin
      repeat ($urandom_range(1, 20)) frame_body.push_back(8'($urandom_range(255)));
      if (kind == 1) begin
        for (int i = 0; i < lpfd_pkg::KEY_LEN; i++) begin
          frame_body.push_back(SIZE_KEY[95 - 8 * i -: 8]);
        end
        repeat ($urandom_range(3)) frame_body.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
      return;
    end
    if (kind == 2) begin
      for (int i = 0; i < 4; i++) frame_body.push_back(SIZE_KEY[95 - 8 * i -: 8]);
    end
    for (int i = 0; i < lpfd_pkg::KEY_LEN; i++) frame_body.push_back(SIZE_KEY[95 - 8 * i -: 8]);
    repeat ($urandom_range(2)) frame_body.push_back(8'($urandom_range(8'h61, 8'h7A)));
    frame_body.push_back(lpfd_pkg::CH_COLON);
    repeat ($urandom_range(3)) begin
      sp = $urandom_range(8, 13);
      frame_body.push_back((sp == 8) ? 8'h20 : 8'(sp));
    end
    case ($urandom_range(6))
      0: frame_body.push_back(lpfd_pkg::CH_PLUS);
      1: frame_body.push_back(lpfd_pkg::CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(9))
      0, 1: begin
        digits = $urandom_range(10, 14);
        repeat (digits) frame_body.push_back(8'($urandom_range(lpfd_pkg::CH_ZERO, 8'h39)));
      end
      2: num = "";
      3: num = $sformatf("00%0d", $urandom_range(20));
      default: num = $sformatf("%0d", $urandom_range(24));
    endcase
    for (int i = 0; i < num.len(); i++) frame_body.push_back(num[i]);
    if ($urandom_range(1)) frame_body.push_back(8'($urandom_range(255)));
    repeat ($urandom_range(3)) frame_body.push_back(8'($urandom_range(255)));
  endtask

  task automatic send_random_frame();
    int cut;
    build_random_body();
    case ($urandom_range(11))
      0: send_header(32'd0);
      1: send_header({8'd0, lim_body} + 32'd1 + $urandom_range(1000));
      default: send_header(frame_body.size());
    endcase
    if (!pred_held) begin
      cut = ($urandom_range(14) == 0) ? int'($urandom_range(frame_body.size() - 1)) : -1;
      foreach (frame_body[i]) begin
        if (i == cut) begin
          send_item(lpfd_pkg::ACT_RESTART, 8'($urandom_range(255)));
          return;
        end
        send_item(lpfd_pkg::ACT_BYTE, frame_body[i]);
      end
    end
    finish_frame();
  endtask

  task automatic test_backpressure();
    drain_results();
    write_limits(32'd65536, 32'd52428800);
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 150;
    repeat (3) send_random_frame();
    drain_results();
  endtask

  task automatic test_random_frames();
    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          write_limits(32'd65536, 32'd52428800);
        end
        1: begin
          idle_pct = 80;
          stall_pct = 0;
          write_limits(32'h00FF_FFFF, 32'hFFFF_FFFF);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 80;
          write_limits({8'($urandom_range(255)), 24'(0)} | $urandom_range(24, 64),
                       $urandom_range(1, 16));
        end
        default: begin
          idle_pct = 11;
          stall_pct = 11;
          write_limits($urandom_range(30, 200), $urandom_range(0, 30));
        end
      endcase
      items_counted = 0;
      while (items_counted < 120) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_item(($urandom_range(3) == 0) ? lpfd_pkg::ACT_RESTART : lpfd_pkg::ACT_BYTE,
                      8'($urandom_range(255)));
          end
          if (pred_phase != lpfd_pkg::PH_HEADER || pred_hdr_idx != 0 || pred_held) begin
            send_item(lpfd_pkg::ACT_RESTART, 8'($urandom_range(255)));
          end
        end else begin
          send_random_frame();
        end
      end
    end
    drain_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = lpfd_pkg::CFG_MAX_BODY;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = lpfd_pkg::ACT_BYTE;
    m_axis_tready = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_request  = 0;
    hold_left     = 0;
    mismatch_count = 0;
    items_counted = 0;
    lim_body      = lpfd_pkg::MAX_BODY_RESET;
    lim_payload   = lpfd_pkg::MAX_PAYLOAD_RESET;
    pred_held     = 1'b0;
    clear_frame_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_errors();
    test_size_key_frame();
    test_limit_extremes();
    test_backpressure();
    test_random_frames();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
